### hw/rtl/qapr_pkg.sv
// ----------------------------------------------------------------------------
// qapr_pkg
// Shared types, register codes and requantize tail for the average-pool core.
// ----------------------------------------------------------------------------
`default_nettype none

package qapr_pkg;

  localparam int unsigned MAX_LANES = 7;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned CFG_W     = 63;

  typedef enum logic [2:0] {
    REG_BIAS       = 3'd0,
    REG_SCALE      = 3'd1,
    REG_ROUND      = 3'd2,
    REG_SHIFT      = 3'd3,
    REG_OFFSET     = 3'd4,
    REG_CLAMP_LOW  = 3'd5,
    REG_CLAMP_HIGH = 3'd6,
    REG_CHANNELS   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] scale_multiplier;
    logic [62:0] rounding_addend;
    logic [5:0]  shift_amount;
    logic [7:0]  output_offset;
    logic [7:0]  clamp_low;
    logic [7:0]  clamp_high;
    logic [2:0]  active_lanes;
  } requant_cfg_t;

  typedef struct packed {
    logic full;
  } queue_ctl_t;

  function automatic logic [7:0] requant_tail(input logic [31:0] low,
                                              input logic        neg,
                                              input logic [7:0]  ofs,
                                              input logic [7:0]  lo,
                                              input logic [7:0]  hi);
    logic [31:0]        v;
    logic signed [17:0] s;
    logic [7:0]         b;
    v = neg ? (~low + 32'd1) : low;
    if ($signed(v) > 32'sd32767) begin
      s = 18'sd32767;
    end else if ($signed(v) < -32'sd32768) begin
      s = -18'sd32768;
    end else begin
      s = $signed(v[17:0]);
    end
    s = s + $signed({10'd0, ofs});
    if (s < 18'sd0) begin
      b = 8'd0;
    end else if (s > 18'sd255) begin
      b = 8'd255;
    end else begin
      b = s[7:0];
    end
    if (b > hi) begin
      b = hi;
    end
    if (b < lo) begin
      b = lo;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/quantized_avg_pool_requant_core.sv
// ----------------------------------------------------------------------------
// quantized_avg_pool_requant_core
// Uint8 average pooling with per-lane accumulate and requantize to bytes.
//
//   Port group  Direction  Handshake          Payload
//   in_*        input      in_valid/in_stall  in_pixel_0..6, in_last_in_window
//   out_*       output     out_valid/out_stall out_0..out_6
//   cfg_*       input      cfg_we             cfg_index, cfg_wdata
//
// One item per cycle is accepted while in_stall is low; the lane sums of a
// window enter the queue at the edge that takes its last beat, then pass the
// 32x32 multiply, round-add and shift/saturate stages before out_valid.
// Reset clears the window flag, queue and pipeline valids; config resets too.
// in_stall rises only while the two-entry queue is full; out_stall holds the
// whole back pipeline while out_valid is high.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_avg_pool_requant_core
  import qapr_pkg::*;
#(
  parameter int unsigned LANES = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_pixel_0,
  input  wire logic [7:0]  in_pixel_1,
  input  wire logic [7:0]  in_pixel_2,
  input  wire logic [7:0]  in_pixel_3,
  input  wire logic [7:0]  in_pixel_4,
  input  wire logic [7:0]  in_pixel_5,
  input  wire logic [7:0]  in_pixel_6,
  input  wire logic        in_last_in_window,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_0,
  output logic [7:0]       out_1,
  output logic [7:0]       out_2,
  output logic [7:0]       out_3,
  output logic [7:0]       out_4,
  output logic [7:0]       out_5,
  output logic [7:0]       out_6,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [62:0] cfg_wdata
);

  logic [31:0] bias_r;
  logic [31:0] scale_r;
  logic [62:0] round_r;
  logic [5:0]  shift_r;
  logic [7:0]  offset_r;
  logic [7:0]  clamp_low_r;
  logic [7:0]  clamp_high_r;
  logic [2:0]  channels_r;

  logic [MAX_LANES-1:0][7:0] pix_all;
  logic [LANES-1:0][7:0]     pix;
  logic                      accept;
  logic                      push;
  logic [LANES*ACC_W-1:0]    sums;
  logic                      q_pop;
  logic                      q_empty;
  logic [LANES*ACC_W-1:0]    q_data;
  queue_ctl_t                q_ctl;
  requant_cfg_t              rq_cfg;
  logic [LANES-1:0][7:0]     lane_out;
  logic [MAX_LANES-1:0][7:0] out_all;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r       <= 32'd0;
      scale_r      <= 32'd1;
      round_r      <= 63'd0;
      shift_r      <= 6'd0;
      offset_r     <= 8'd0;
      clamp_low_r  <= 8'd0;
      clamp_high_r <= 8'd255;
      channels_r   <= 3'd7;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BIAS:       bias_r       <= cfg_wdata[31:0];
        REG_SCALE:      scale_r      <= cfg_wdata[31:0];
        REG_ROUND:      round_r      <= cfg_wdata;
        REG_SHIFT:      shift_r      <= cfg_wdata[5:0];
        REG_OFFSET:     offset_r     <= cfg_wdata[7:0];
        REG_CLAMP_LOW:  clamp_low_r  <= cfg_wdata[7:0];
        REG_CLAMP_HIGH: clamp_high_r <= cfg_wdata[7:0];
        REG_CHANNELS:   channels_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign pix_all = {in_pixel_6, in_pixel_5, in_pixel_4, in_pixel_3,
                    in_pixel_2, in_pixel_1, in_pixel_0};
  assign pix      = pix_all[LANES-1:0];
  assign in_stall = q_ctl.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    rq_cfg.scale_multiplier = scale_r;
    rq_cfg.rounding_addend  = round_r;
    rq_cfg.shift_amount     = shift_r;
    rq_cfg.output_offset    = offset_r;
    rq_cfg.clamp_low        = clamp_low_r;
    rq_cfg.clamp_high       = clamp_high_r;
    rq_cfg.active_lanes     = (channels_r < 3'(LANES)) ? channels_r : 3'(LANES);
  end

  qapr_front #(.LANES(LANES)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .pixel  (pix),
    .last   (in_last_in_window),
    .bias   (bias_r),
    .push   (push),
    .sums   (sums)
  );

  qapr_queue #(.WIDTH(LANES*ACC_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (sums),
    .pop       (q_pop),
    .ctl       (q_ctl),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  qapr_back #(.LANES(LANES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .cfg       (rq_cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (lane_out)
  );

  always_comb begin
    out_all = '0;
    for (int k = 0; k < LANES; k++) begin
      out_all[k] = lane_out[k];
    end
  end

  assign out_0 = out_all[0];
  assign out_1 = out_all[1];
  assign out_2 = out_all[2];
  assign out_3 = out_all[3];
  assign out_4 = out_all[4];
  assign out_5 = out_all[5];
  assign out_6 = out_all[6];

endmodule

`default_nettype wire

### hw/rtl/qapr_front.sv
// ----------------------------------------------------------------------------
// qapr_front
// Per-lane window accumulators; pushes the closed window's sums to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qapr_front
  import qapr_pkg::*;
#(
  parameter int unsigned LANES = 7
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire logic [LANES-1:0][7:0]  pixel,
  input  wire logic                   last,
  input  wire logic [31:0]            bias,
  output logic                        push,
  output logic [LANES*ACC_W-1:0]      sums
);

  logic                        window_open_r;
  logic                        window_open_nxt;
  logic [LANES-1:0][ACC_W-1:0] lane_sum_r;
  logic [LANES-1:0][ACC_W-1:0] lane_sum_nxt;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_sum_nxt[k] = (window_open_r ? lane_sum_r[k] : bias) + {24'd0, pixel[k]};
    end
    window_open_nxt = window_open_r;
    if (accept) begin
      window_open_nxt = !last;
    end
  end

  assign push = accept && last;
  assign sums = lane_sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_open_r <= 1'b0;
    end else begin
      window_open_r <= window_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lane_sum_r <= lane_sum_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/qapr_queue.sv
// ----------------------------------------------------------------------------
// qapr_queue
// Two-entry queue of closed-window lane sums between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module qapr_queue
  import qapr_pkg::*;
#(
  parameter int unsigned WIDTH = 224
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output queue_ctl_t            ctl,
  output logic                  empty,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_r;
  logic             rd_ptr_nxt;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;
  logic             do_pop;

  assign do_pop   = pop && (count_r != 2'd0);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem[rd_ptr_r];
  assign ctl.full = (count_r == 2'd2);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/qapr_back.sv
// ----------------------------------------------------------------------------
// qapr_back
// Requantize pipeline: multiply, round, shift and saturate, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qapr_back
  import qapr_pkg::*;
#(
  parameter int unsigned LANES = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  input  wire logic [LANES*ACC_W-1:0] q_data,
  output logic                       q_pop,
  input  wire requant_cfg_t          cfg,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [LANES-1:0][7:0]      out_byte
);

  logic                     adv;
  logic                     mul_vld_r;
  logic                     mul_vld_nxt;
  logic                     rnd_vld_r;
  logic                     rnd_vld_nxt;
  logic                     out_vld_r;
  logic                     out_vld_nxt;
  logic [LANES-1:0]         mul_neg_r;
  logic [LANES-1:0]         rnd_neg_r;
  logic [LANES-1:0][63:0]   prod_r;
  logic [LANES-1:0][63:0]   rnd_r;
  logic [LANES-1:0][7:0]    byte_r;
  logic [LANES-1:0][63:0]   prod_nxt;
  logic [LANES-1:0][63:0]   rnd_nxt;
  logic [LANES-1:0][7:0]    byte_nxt;
  logic [LANES-1:0]         neg_nxt;
  logic [LANES-1:0][63:0]   shifted;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         mag;

  assign adv   = !out_vld_r || !out_stall;
  assign q_pop = adv && !q_empty;

  always_comb begin
    acc = '0;
    mag = '0;
    for (int k = 0; k < LANES; k++) begin
      acc         = q_data[k*ACC_W +: ACC_W];
      neg_nxt[k]  = acc[ACC_W-1];
      mag         = acc[ACC_W-1] ? (~acc + 32'd1) : acc;
      prod_nxt[k] = {32'd0, mag} * {32'd0, cfg.scale_multiplier};
      rnd_nxt[k]  = prod_r[k] + {1'b0, cfg.rounding_addend};
      shifted[k]  = rnd_r[k] >> cfg.shift_amount;
      if (3'(k) < cfg.active_lanes) begin
        byte_nxt[k] = requant_tail(shifted[k][31:0], rnd_neg_r[k], cfg.output_offset,
                                   cfg.clamp_low, cfg.clamp_high);
      end else begin
        byte_nxt[k] = 8'd0;
      end
    end
    mul_vld_nxt = adv ? q_pop     : mul_vld_r;
    rnd_vld_nxt = adv ? mul_vld_r : rnd_vld_r;
    out_vld_nxt = adv ? rnd_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      rnd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= mul_vld_nxt;
      rnd_vld_r <= rnd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r    <= prod_nxt;
      mul_neg_r <= neg_nxt;
      rnd_r     <= rnd_nxt;
      rnd_neg_r <= mul_neg_r;
      byte_r    <= byte_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_byte  = byte_r;

endmodule

`default_nettype wire

### tb/quantized_avg_pool_requant_core_tb.sv
// ----------------------------------------------------------------------------
// quantized_avg_pool_requant_core_tb
// Self-checking bench for the uint8 average-pool and requantize core.
//
// A directed drill of window beats and register writes runs first. It covers
// full and empty bytes, reduced and zero lane counts, the most negative
// accumulator, accumulator wrap, an inverted clamp, a bias write while a
// window is open, and extreme multiplier, rounding and shift values. Random
// phases follow. Each phase programs every register and then streams windows
// of random length and content. A pool model predicts each result that no
// drill row fixes, and each delivered beat is compared lane by lane in order.
// Both sides idle and stall at random. One phase runs with no gaps at all, and
// one holds the result side off long enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quantized_avg_pool_requant_core_tb;
  import qapr_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1500;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned NUM_DRILL    = 38;

  typedef logic [6:0][7:0] lane_bytes_t;

  typedef enum bit {ROW_BEAT, ROW_WRITE} drill_kind_t;

  typedef struct {
    drill_kind_t kind;
    cfg_reg_t    sel;
    logic [62:0] value;
    lane_bytes_t pix;
    bit          last;
    bit          fixed;
    lane_bytes_t want;
  } drill_row_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  lane_bytes_t beat_pix     = '0;
  logic        beat_last    = 1'b0;
  bit          beat_fixed   = 1'b0;
  lane_bytes_t beat_want    = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [7:0]  out_0, out_1, out_2, out_3, out_4, out_5, out_6;
  logic        cfg_we       = 1'b0;
  cfg_reg_t    cfg_sel      = REG_BIAS;
  logic [62:0] cfg_wdata    = '0;

  int unsigned idle_pct     = 28;
  int unsigned stall_pct    = 28;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  // pool model: register copies at reset values, lane accumulators
  logic [31:0] m_bias      = 32'd0;
  logic [31:0] m_scale     = 32'd1;
  logic [62:0] m_round     = '0;
  logic [5:0]  m_shift     = 6'd0;
  logic [7:0]  m_offset    = 8'd0;
  logic [7:0]  m_clamp_lo  = 8'd0;
  logic [7:0]  m_clamp_hi  = 8'd255;
  logic [2:0]  m_lanes     = 3'd7;
  logic [31:0] lane_acc [7];
  bit          window_live = 1'b0;

  lane_bytes_t pending_pools [$];

  drill_row_t drill [NUM_DRILL] = '{
    '{ROW_BEAT,  REG_BIAS,       63'd0, '0,                 1'b1, 1'b1, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, {7{8'hFF}},         1'b1, 1'b1, {7{8'hFF}}},
    '{ROW_BEAT,  REG_BIAS,       63'd0, 56'h07060504030201, 1'b0, 1'b0, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, 56'h80C0E0F0F8FCFE, 1'b1, 1'b0, '0},
    '{ROW_WRITE, REG_CHANNELS,   63'd3, '0,                 1'b0, 1'b0, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, {7{8'hFF}},         1'b1, 1'b1, 56'h00000000FFFFFF},
    '{ROW_WRITE, REG_CHANNELS,   63'd0, '0,                 1'b0, 1'b0, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, {7{8'hFF}},         1'b1, 1'b1, '0},
    '{ROW_WRITE, REG_CHANNELS,   63'd7, '0,                 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_BIAS,       63'h80000000, '0,          1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_SHIFT,      63'd24, '0,                1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_OFFSET,     63'd255, '0,               1'b0, 1'b0, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, '0,                 1'b1, 1'b1, {7{8'h7F}}},
    '{ROW_BEAT,  REG_BIAS,       63'd0, {7{8'hFF}},         1'b1, 1'b0, '0},
    '{ROW_WRITE, REG_CLAMP_LOW,  63'd200, '0,               1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_CLAMP_HIGH, 63'd100, '0,               1'b0, 1'b0, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, 56'h00FF00FF00FF00, 1'b1, 1'b1, {7{8'hC8}}},
    '{ROW_WRITE, REG_CLAMP_LOW,  63'd0, '0,                 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_CLAMP_HIGH, 63'd255, '0,               1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_OFFSET,     63'd0, '0,                 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_SHIFT,      63'd0, '0,                 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_BIAS,       63'h7FFFFFFF, '0,          1'b0, 1'b0, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, {7{8'h01}},         1'b1, 1'b1, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, {7{8'h5A}},         1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_BIAS,       63'd0, '0,                 1'b0, 1'b0, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, {7{8'hFF}},         1'b1, 1'b0, '0},
    '{ROW_WRITE, REG_SCALE,      63'hFFFFFFFF, '0,          1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_ROUND,      63'h7FFFFFFFFFFFFFFF, '0,  1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_SHIFT,      63'd63, '0,                1'b0, 1'b0, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, {7{8'hFF}},         1'b1, 1'b0, '0},
    '{ROW_WRITE, REG_SHIFT,      63'd32, '0,                1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_ROUND,      63'd0, '0,                 1'b0, 1'b0, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, 56'h123456789ABCDE, 1'b1, 1'b0, '0},
    '{ROW_WRITE, REG_OFFSET,     63'd255, '0,               1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_BIAS,       63'h00010000, '0,          1'b0, 1'b0, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, 56'hAA55AA55AA55AA, 1'b1, 1'b0, '0},
    '{ROW_WRITE, REG_SCALE,      63'd0, '0,                 1'b0, 1'b0, '0},
    '{ROW_BEAT,  REG_BIAS,       63'd0, {7{8'hFF}},         1'b1, 1'b1, {7{8'hFF}}}
  };

  quantized_avg_pool_requant_core #(.LANES(7)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel_0        (beat_pix[0]),
    .in_pixel_1        (beat_pix[1]),
    .in_pixel_2        (beat_pix[2]),
    .in_pixel_3        (beat_pix[3]),
    .in_pixel_4        (beat_pix[4]),
    .in_pixel_5        (beat_pix[5]),
    .in_pixel_6        (beat_pix[6]),
    .in_last_in_window (beat_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_0             (out_0),
    .out_1             (out_1),
    .out_2             (out_2),
    .out_3             (out_3),
    .out_4             (out_4),
    .out_5             (out_5),
    .out_6             (out_6),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_sel),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void apply_write(input cfg_reg_t sel, input logic [62:0] v);
    case (sel)
      REG_BIAS:       m_bias     = v[31:0];
      REG_SCALE:      m_scale    = v[31:0];
      REG_ROUND:      m_round    = v;
      REG_SHIFT:      m_shift    = v[5:0];
      REG_OFFSET:     m_offset   = v[7:0];
      REG_CLAMP_LOW:  m_clamp_lo = v[7:0];
      REG_CLAMP_HIGH: m_clamp_hi = v[7:0];
      REG_CHANNELS:   m_lanes    = v[2:0];
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] requant_byte(input logic [31:0] acc);
    logic        neg;
    logic [31:0] mag;
    logic [31:0] low;
    logic [63:0] prod;
    logic [63:0] scaled;
    int          val;
    logic [7:0]  b;
    neg    = acc[31];
    mag    = neg ? (32'd0 - acc) : acc;
    prod   = 64'(mag) * 64'(m_scale);
    scaled = (prod + 64'(m_round)) >> m_shift;
    low    = scaled[31:0];
    val    = $signed(neg ? (32'd0 - low) : low);
    if (val > 32767) begin
      val = 32767;
    end else if (val < -32768) begin
      val = -32768;
    end
    val = val + int'(m_offset);
    if (val > 32767) begin
      val = 32767;
    end
    if (val < 0) begin
      b = 8'd0;
    end else if (val > 255) begin
      b = 8'd255;
    end else begin
      b = val[7:0];
    end
    if (b > m_clamp_hi) begin
      b = m_clamp_hi;
    end
    if (b < m_clamp_lo) begin
      b = m_clamp_lo;
    end
    return b;
  endfunction

  // accumulate one window element; returns 1 when the window closes
  function automatic bit pool_step(input lane_bytes_t pix, input logic last,
                                   output lane_bytes_t pooled);
    pooled = '0;
    for (int k = 0; k < 7; k++) begin
      if (!window_live) begin
        lane_acc[k] = m_bias;
      end
      lane_acc[k] = lane_acc[k] + 32'(pix[k]);
    end
    if (!last) begin
      window_live = 1'b1;
      return 1'b0;
    end
    window_live = 1'b0;
    for (int k = 0; k < 7; k++) begin
      if (k < int'(m_lanes)) begin
        pooled[k] = requant_byte(lane_acc[k]);
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : scoreboard
    lane_bytes_t pooled;
    lane_bytes_t got;
    lane_bytes_t want;
    if (rst_n) begin
      if (cfg_we) begin
        apply_write(cfg_sel, cfg_wdata);
      end
      if (in_valid && !in_stall) begin
        if (pool_step(beat_pix, beat_last, pooled)) begin
          pending_pools.push_back(beat_fixed ? beat_want : pooled);
        end
      end
      if (out_valid && !out_stall) begin
        got = {out_6, out_5, out_4, out_3, out_2, out_1, out_0};
        if (pending_pools.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat %014h", got));
        end else begin
          want = pending_pools.pop_front();
          for (int k = 0; k < 7; k++) begin
            if (got[k] !== want[k]) begin
              report_mismatch($sformatf("lane %0d got %02h want %02h", k, got[k], want[k]));
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("quantized_avg_pool_requant_core verification failed");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_beat(input lane_bytes_t pix, input logic last,
                           input bit fixed, input lane_bytes_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    beat_pix   <= pix;
    beat_last  <= last;
    beat_fixed <= fixed;
    beat_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // drain all results, let the pipeline empty, then write one register
  task automatic write_reg(input cfg_reg_t sel, input logic [62:0] v);
    in_valid <= 1'b0;
    while (pending_pools.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_sel   <= sel;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_phase(input int unsigned mode);
    logic [31:0] bias;
    logic [31:0] scale;
    logic [62:0] rnd;
    logic [5:0]  shift;
    logic [7:0]  ofs;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [2:0]  lanes;
    ofs   = 8'($urandom);
    lo    = 8'($urandom_range(0, 80));
    hi    = 8'($urandom_range(150, 255));
    lanes = 3'($urandom_range(1, 7));
    case (mode)
      0: begin
        bias  = 32'($urandom_range(0, 4000)) - 32'd2000;
        scale = $urandom | 32'h4000_0000;
        shift = 6'($urandom_range(31, 40));
        rnd   = 63'(1) << (shift - 6'd1);
      end
      1: begin
        bias  = 32'($urandom_range(0, 60000)) - 32'd30000;
        scale = 32'($urandom_range(0, 300));
        shift = 6'($urandom_range(0, 12));
        rnd   = 63'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) == 0) begin
          lo = 8'($urandom_range(128, 255));
          hi = 8'($urandom_range(0, 127));
        end
      end
      2: begin
        bias  = $urandom;
        scale = $urandom;
        shift = 6'($urandom);
        rnd   = 63'({$urandom, $urandom});
        lo    = 8'($urandom);
        hi    = 8'($urandom);
        lanes = 3'($urandom);
      end
      default: begin
        bias  = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        scale = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
        shift = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        rnd   = $urandom_range(0, 1) ? {63{1'b1}} : 63'd0;
        ofs   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        lo    = $urandom_range(0, 3) == 0 ? 8'd255 : 8'd0;
        hi    = $urandom_range(0, 3) == 0 ? 8'd0 : 8'd255;
        lanes = $urandom_range(0, 3) == 0 ? 3'd0 : 3'd7;
      end
    endcase
    write_reg(REG_BIAS, 63'(bias));
    write_reg(REG_SCALE, 63'(scale));
    write_reg(REG_ROUND, rnd);
    write_reg(REG_SHIFT, 63'(shift));
    write_reg(REG_OFFSET, 63'(ofs));
    write_reg(REG_CLAMP_LOW, 63'(lo));
    write_reg(REG_CLAMP_HIGH, 63'(hi));
    write_reg(REG_CHANNELS, 63'(lanes));
  endtask

  initial begin : stimulus
    int unsigned random_beats;
    int unsigned phase;
    int unsigned nwin;
    int unsigned len;
    int unsigned pick;
    int unsigned mode;
    lane_bytes_t pix;
    random_beats = 0;
    phase = 0;
    for (int k = 0; k < 7; k++) begin
      lane_acc[k] = 32'd0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < NUM_DRILL; r++) begin
      if (drill[r].kind == ROW_WRITE) begin
        write_reg(drill[r].sel, drill[r].value);
      end else begin
        send_beat(drill[r].pix, drill[r].last, drill[r].fixed, drill[r].want);
      end
    end

    while (random_beats < RANDOM_BEATS) begin
      pick = $urandom_range(0, 9);
      mode = (pick < 5) ? 0 : (pick < 7) ? 1 : (pick < 9) ? 2 : 3;
      if (phase == 0 || phase == 1 || phase == 3) begin
        mode = 0;
      end
      program_phase(mode);
      idle_pct  = (phase == 1 || phase == 3) ? 0 : 28;
      stall_pct = (phase == 1) ? 0 : 28;
      if (phase == 3) begin
        hold_request = 1'b1;
      end
      nwin = $urandom_range(8, 20);
      for (int w = 0; w < int'(nwin); w++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
        for (int b = 1; b <= int'(len); b++) begin
          pick = $urandom_range(0, 19);
          if (pick < 2) begin
            pix = {7{8'hFF}};
          end else if (pick == 2) begin
            pix = '0;
          end else begin
            pix = 56'({$urandom, $urandom});
          end
          send_beat(pix, b == int'(len), 1'b0, '0);
          random_beats++;
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    idle_pct  = 28;
    stall_pct = 28;
    while (pending_pools.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_pools.size() == 0) begin
      $display("quantized_avg_pool_requant_core verification clean");
    end else begin
      $display("quantized_avg_pool_requant_core verification failed");
    end
    $finish;
  end

endmodule

### quantized_avg_pool_requant_core.f
hw/rtl/qapr_pkg.sv
hw/rtl/qapr_front.sv
hw/rtl/qapr_queue.sv
hw/rtl/qapr_back.sv
hw/rtl/quantized_avg_pool_requant_core.sv
tb/quantized_avg_pool_requant_core_tb.sv
